### rtl/ohlc_pkg.sv
// Shared types and constants for the tick to OHLC bar aggregator.
`default_nettype none

package ohlc_pkg;

  localparam int TS_W    = 40;
  localparam int PRICE_W = 32;
  localparam int LEN_W   = 17;

  localparam logic [LEN_W-1:0] BAR_SECONDS_RESET = LEN_W'(60);

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = TS_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic                 is_flush;
    logic [TS_W-1:0]      start;
    logic [PRICE_W-1:0]   mid;
  } queue_entry_t;

  typedef struct packed {
    logic [TS_W-1:0]    bar_start;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [PRICE_W-1:0] tick_count;
  } bar_t;

endpackage

`default_nettype wire

### rtl/ohlc_front.sv
// Front end: accepts ticks, drops invalid ones, forms the mid price and the bar start.
`default_nettype none

module ohlc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ohlc_pkg::LEN_W-1:0]   bar_seconds,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         cmd,
  input  wire logic [ohlc_pkg::TS_W-1:0]    timestamp,
  input  wire logic [ohlc_pkg::PRICE_W-1:0] bid,
  input  wire logic [ohlc_pkg::PRICE_W-1:0] ask,
  output logic                              push_valid,
  output ohlc_pkg::queue_entry_t            push_entry,
  input  wire logic                         queue_full
);
  import ohlc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DIV_STEPS - 1);

  state_t             state;
  logic [LEN_W-1:0]   bar_len;
  logic [LEN_W-1:0]   len_eff;
  logic [TS_W-1:0]    ts_hold;
  logic [TS_W-1:0]    ts_shift;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   rem_next;
  logic [CNT_W-1:0]   step_cnt;
  logic               is_flush;
  logic [PRICE_W-1:0] mid;
  logic [PRICE_W:0]   mid_sum;

  assign len_eff = (bar_len == '0) ? LEN_W'(1) : bar_len;
  assign mid_sum = {1'b0, bid} + {1'b0, ask};

  always_comb begin : div_step
    logic [LEN_W:0]   trial;
    logic [LEN_W-1:0] r;
    r = rem;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r, ts_shift[TS_W-1-i]};
      if (trial >= {1'b0, len_eff}) begin
        trial = trial - {1'b0, len_eff};
      end
      r = trial[LEN_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bar_len <= BAR_SECONDS_RESET;
    end else begin
      if (cfg_valid) begin
        bar_len <= bar_seconds;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_FLUSH) begin
              is_flush <= 1'b1;
              state    <= ST_PUSH;
            end else if (bid != '0 && ask != '0) begin
              is_flush <= 1'b0;
              mid      <= mid_sum[PRICE_W:1];
              ts_hold  <= timestamp;
              ts_shift <= timestamp;
              rem      <= '0;
              step_cnt <= '0;
              state    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem      <= rem_next;
          ts_shift <= ts_shift << DIV_BITS;
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == STEP_LAST) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!queue_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready           = 1'b1;
  assign in_stall            = (state != ST_IDLE);
  assign push_valid          = (state == ST_PUSH);
  assign push_entry.is_flush = is_flush;
  assign push_entry.start    = ts_hold - {{(TS_W-LEN_W){1'b0}}, rem};
  assign push_entry.mid      = mid;

endmodule

`default_nettype wire

### rtl/ohlc_queue.sv
// Short queue of classified ticks between the front end and the bar logic.
`default_nettype none

module ohlc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push_valid,
  input  wire ohlc_pkg::queue_entry_t  push_entry,
  output logic                         queue_full,
  input  wire logic                    pop_ready,
  output logic                         queue_empty,
  output ohlc_pkg::queue_entry_t       head_entry
);
  import ohlc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  queue_entry_t      slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign queue_full  = (fill == CNT_FULL);
  assign queue_empty = (fill == '0);
  assign do_push     = push_valid && !queue_full;
  assign do_pop      = pop_ready && !queue_empty;
  assign head_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ohlc_back.sv
// Bar logic: keeps the open bar and registers each finished bar for output.
`default_nettype none

module ohlc_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    queue_empty,
  input  wire ohlc_pkg::queue_entry_t  head_entry,
  output logic                         pop_ready,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output ohlc_pkg::bar_t               result
);
  import ohlc_pkg::*;

  logic               bar_open;
  logic [TS_W-1:0]    cur_start;
  logic [PRICE_W-1:0] open_reg;
  logic [PRICE_W-1:0] high_reg;
  logic [PRICE_W-1:0] low_reg;
  logic [PRICE_W-1:0] close_reg;
  logic [PRICE_W-1:0] count_reg;
  logic               take;
  logic               new_bar;
  logic               emit;

  assign pop_ready = !out_valid || !out_stall;
  assign take      = pop_ready && !queue_empty;
  assign new_bar   = !head_entry.is_flush && (!bar_open || head_entry.start != cur_start);
  assign emit      = take && bar_open && (head_entry.is_flush || new_bar);

  always_ff @(posedge clk) begin
    if (emit) begin
      result.bar_start   <= cur_start;
      result.open_price  <= open_reg;
      result.high_price  <= high_reg;
      result.low_price   <= low_reg;
      result.close_price <= close_reg;
      result.tick_count  <= count_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bar_open  <= 1'b0;
      cur_start <= '0;
      open_reg  <= '0;
      high_reg  <= '0;
      low_reg   <= '0;
      close_reg <= '0;
      count_reg <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (head_entry.is_flush) begin
          bar_open  <= 1'b0;
          cur_start <= '0;
          open_reg  <= '0;
          high_reg  <= '0;
          low_reg   <= '0;
          close_reg <= '0;
          count_reg <= '0;
        end else if (new_bar) begin
          bar_open  <= 1'b1;
          cur_start <= head_entry.start;
          open_reg  <= head_entry.mid;
          high_reg  <= head_entry.mid;
          low_reg   <= head_entry.mid;
          close_reg <= head_entry.mid;
          count_reg <= PRICE_W'(1);
        end else begin
          if (head_entry.mid > high_reg) begin
            high_reg <= head_entry.mid;
          end
          if (head_entry.mid < low_reg) begin
            low_reg <= head_entry.mid;
          end
          close_reg <= head_entry.mid;
          if (count_reg != '1) begin
            count_reg <= count_reg + PRICE_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tick_to_ohlc_bar_aggregator.sv
// Top level of the tick to OHLC bar aggregator.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   cfg     | cfg_valid, cfg_ready | bar_seconds
//   in      | in_valid, in_stall   | cmd, timestamp, bid, ask
//   out     | out_valid, out_stall | bar_start, open/high/low/close_price, tick_count
//
// A valid tick holds the input while it is accepted, while the bar start remainder
// unit works at four timestamp bits per cycle, and until the queue takes it.
// A flush is accepted and then enters the queue; a tick with a zero price is dropped.
// Reset restores a bar length of 60 seconds and leaves no bar open.
// The bar logic drains the queue while out_stall is low or no result is held.
`default_nettype none

module tick_to_ohlc_bar_aggregator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ohlc_pkg::LEN_W-1:0]   bar_seconds,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         cmd,
  input  wire logic [ohlc_pkg::TS_W-1:0]    timestamp,
  input  wire logic [ohlc_pkg::PRICE_W-1:0] bid,
  input  wire logic [ohlc_pkg::PRICE_W-1:0] ask,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ohlc_pkg::TS_W-1:0]         bar_start,
  output logic [ohlc_pkg::PRICE_W-1:0]      open_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      high_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      low_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      close_price,
  output logic [ohlc_pkg::PRICE_W-1:0]      tick_count
);
  import ohlc_pkg::*;

  logic         push_valid;
  queue_entry_t push_entry;
  logic         queue_full;
  logic         pop_ready;
  logic         queue_empty;
  queue_entry_t head_entry;
  bar_t         result;

  ohlc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .bar_seconds(bar_seconds),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .timestamp  (timestamp),
    .bid        (bid),
    .ask        (ask),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  ohlc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .queue_full (queue_full),
    .pop_ready  (pop_ready),
    .queue_empty(queue_empty),
    .head_entry (head_entry)
  );

  ohlc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(queue_empty),
    .head_entry (head_entry),
    .pop_ready  (pop_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign bar_start   = result.bar_start;
  assign open_price  = result.open_price;
  assign high_price  = result.high_price;
  assign low_price   = result.low_price;
  assign close_price = result.close_price;
  assign tick_count  = result.tick_count;

endmodule

`default_nettype wire
